[hdl/cmt_pkg.sv]
`default_nettype none

package cmt_pkg;

    localparam int DEF_MAX_COLUMNS = 512;
    localparam int OFFSET_W        = 13;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 12;

    localparam logic [1:0] MODE_SEED  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTICAL_SCALE = 2'd2;

    localparam logic [9:0]  COLUMN_COUNT_RST   = 10'd320;
    localparam logic [11:0] ROW_COUNT_RST      = 12'd200;
    localparam logic [3:0]  VERTICAL_SCALE_RST = 4'd1;

    // offsets below this drop by offset plus one, the rest by a fixed step, times the vertical scale
    localparam logic [4:0] FAST_LIMIT = 5'd16;
    localparam logic [4:0] SLOW_STEP  = 5'd8;
    localparam logic signed [5:0] SEED_FLOOR = -6'sd15;

    typedef struct packed {
        logic [1:0]  mode;
        logic [8:0]  column;
        logic [10:0] row;
        logic [7:0]  random_value;
        logic [7:0]  tick_count;
    } in_item_t;

    typedef struct packed {
        logic        from_end_frame;
        logic [10:0] source_row;
        logic        done_res;
    } out_item_t;

    typedef struct packed {
        logic issue;
        logic busy;
        logic drain;
    } walk_ctl_t;

    // base-4 digits are each congruent to themselves mod 3
    function automatic logic [1:0] mod3_byte(input logic [7:0] value);
        logic [3:0] digit_sum;
        logic [1:0] remainder;
        digit_sum = 4'(value[1:0]) + 4'(value[3:2]) + 4'(value[5:4]) + 4'(value[7:6]);
        if (digit_sum inside {4'd1, 4'd4, 4'd7, 4'd10})
        begin
            remainder = 2'd1;
        end
        else if (digit_sum inside {4'd2, 4'd5, 4'd8, 4'd11})
        begin
            remainder = 2'd2;
        end
        else
        begin
            remainder = 2'd0;
        end
        return remainder;
    endfunction

endpackage

`default_nettype wire

[hdl/column_melt_transition.sv]
// seed and query: one transfer per cycle unless out_stall holds; result via s1 then out_reg
// tick: input stalls through tick_count passes over the active columns and the drain, one column
//   read and written back per cycle through the dual-port offset memory; zero work skips the walk
// reset clears configuration to defaults, the previous seed and all control state; offset memory
//   is not cleared; the user must seed every column before it is ticked or queried (not checked)
`default_nettype none

module column_melt_transition
    import cmt_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_item_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_item_t                   out_data,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W   = $clog2(MAX_COLUMNS);
    localparam int ACTIVE_W = $clog2(MAX_COLUMNS + 1);

    typedef enum logic [1:0] {K_ZERO, K_QUERY, K_DONE, K_MELT} stage_kind_t;

    logic [9:0]  column_count_reg;
    logic [11:0] row_count_reg;
    logic [3:0]  vertical_scale_reg;

    logic              s1_valid_reg, s1_valid_next;
    stage_kind_t       s1_kind_reg, s1_kind_next;
    logic [ADDR_W-1:0] s1_addr_reg, s1_addr_next;
    logic [10:0]       s1_row_reg, s1_row_next;
    logic              s1_col_ok_reg, s1_col_ok_next;
    logic              s1_done_reg, s1_done_next;
    logic              moved_reg, moved_next;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic                in_accept;
    logic                s1_hold;
    logic                s1_move;
    logic                column_ok;
    logic [ACTIVE_W-1:0] active;
    logic                tick_work;
    logic                walk_start;
    logic [ADDR_W-1:0]   last_column;
    logic                seed_load;
    logic                query_read;
    logic                melt_write;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [OFFSET_W-1:0] mem_wdata;
    logic                mem_re;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [OFFSET_W-1:0] rd_data;
    logic [OFFSET_W-1:0] alu_offset;
    logic [OFFSET_W-1:0] melt_offset;
    logic                melt_moved;
    out_item_t           query_result;
    out_item_t           result_next;
    logic [OFFSET_W-1:0] seed_offset;
    walk_ctl_t           walk_ctl;
    logic [ADDR_W-1:0]   walk_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg   <= COLUMN_COUNT_RST;
            row_count_reg      <= ROW_COUNT_RST;
            vertical_scale_reg <= VERTICAL_SCALE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_COLUMN_COUNT:   column_count_reg   <= cfg_data[9:0];
                CFG_ROW_COUNT:      row_count_reg      <= cfg_data[11:0];
                CFG_VERTICAL_SCALE: vertical_scale_reg <= cfg_data[3:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        s1_hold   = s1_valid_reg && (s1_kind_reg != K_MELT) && out_valid_reg && out_stall;
        s1_move   = s1_valid_reg && (s1_kind_reg != K_MELT) && !s1_hold;
        in_stall  = walk_ctl.busy || s1_hold;
        in_accept = in_valid && !in_stall;

        column_ok = 32'(in_data.column) < 32'(MAX_COLUMNS);
        active    = (32'(column_count_reg) >= 32'(MAX_COLUMNS)) ? ACTIVE_W'(MAX_COLUMNS)
                                                               : ACTIVE_W'(column_count_reg);
        tick_work   = (in_data.tick_count != 8'd0) && (active != '0);
        last_column = ADDR_W'(active - ACTIVE_W'(1));
        walk_start  = in_accept && (in_data.mode == MODE_TICK) && tick_work;
        seed_load   = in_accept && (in_data.mode == MODE_SEED) && column_ok;
        query_read  = in_accept && (in_data.mode == MODE_QUERY) && column_ok;

        melt_write = s1_valid_reg && (s1_kind_reg == K_MELT);
        mem_we     = melt_write || seed_load;
        mem_waddr  = melt_write ? s1_addr_reg : ADDR_W'(in_data.column);
        mem_wdata  = melt_write ? melt_offset : seed_offset;
        mem_re     = walk_ctl.issue || query_read;
        mem_raddr  = walk_ctl.issue ? walk_addr : ADDR_W'(in_data.column);

        // a query beyond the column range sees offset zero
        alu_offset = ((s1_kind_reg == K_QUERY) && !s1_col_ok_reg) ? '0 : rd_data;
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        s1_kind_next   = s1_kind_reg;
        s1_addr_next   = s1_addr_reg;
        s1_row_next    = s1_row_reg;
        s1_col_ok_next = s1_col_ok_reg;
        s1_done_next   = s1_done_reg;

        if (walk_ctl.issue)
        begin
            s1_valid_next = 1'b1;
            s1_kind_next  = K_MELT;
            s1_addr_next  = walk_addr;
        end
        else if (walk_ctl.drain)
        begin
            s1_valid_next = 1'b1;
            s1_kind_next  = K_DONE;
            s1_done_next  = !(moved_reg || melt_moved);
        end
        else if (in_accept)
        begin
            s1_valid_next  = 1'b1;
            s1_row_next    = in_data.row;
            s1_col_ok_next = column_ok;
            case (in_data.mode)
                MODE_QUERY:
                begin
                    s1_kind_next = K_QUERY;
                end
                MODE_TICK:
                begin
                    s1_valid_next = !tick_work;
                    s1_kind_next  = K_DONE;
                    s1_done_next  = 1'b1;
                end
                default:
                begin
                    s1_kind_next = K_ZERO;
                end
            endcase
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        if (walk_start)
        begin
            moved_next = 1'b0;
        end
        else if (melt_write)
        begin
            moved_next = moved_reg || melt_moved;
        end
        else
        begin
            moved_next = moved_reg;
        end

        case (s1_kind_reg)
            K_QUERY:
            begin
                result_next = query_result;
            end
            K_DONE:
            begin
                result_next          = '0;
                result_next.done_res = s1_done_reg;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_kind_reg   <= K_ZERO;
            moved_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_kind_reg  <= s1_kind_next;
            moved_reg    <= moved_next;
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg   <= s1_addr_next;
        s1_row_reg    <= s1_row_next;
        s1_col_ok_reg <= s1_col_ok_next;
        s1_done_reg   <= s1_done_next;
        if (s1_move)
        begin
            out_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    cmt_offset_ram #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_offset_ram (
        .clk        (clk),
        .rst_n      (rst_n),
        .write_en   (mem_we),
        .write_addr (mem_waddr),
        .write_data (mem_wdata),
        .read_en    (mem_re),
        .read_addr  (mem_raddr),
        .read_data  (rd_data)
    );

    cmt_seed_unit u_seed_unit (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (seed_load),
        .column         (in_data.column),
        .random_value   (in_data.random_value),
        .vertical_scale (vertical_scale_reg),
        .offset         (seed_offset)
    );

    cmt_column_alu u_column_alu (
        .offset         (alu_offset),
        .row_count      (row_count_reg),
        .vertical_scale (vertical_scale_reg),
        .row            (s1_row_reg),
        .melt_offset    (melt_offset),
        .melt_moved     (melt_moved),
        .query_result   (query_result)
    );

    cmt_walker #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (walk_start),
        .last_column (last_column),
        .last_pass   (in_data.tick_count - 8'd1),
        .ctl         (walk_ctl),
        .addr        (walk_addr)
    );

    // write-back of a column happens only inside a tick walk
    a_melt_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_kind_reg == K_MELT)) |-> walk_ctl.busy)
        else $error("melt write-back outside a walk");

    // a tick with work starts the walker
    a_tick_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_data.mode == MODE_TICK) && tick_work) |=> walk_ctl.issue)
        else $error("tick transfer did not start the walk");

    // the done result follows the last write-back
    a_drain_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        walk_ctl.drain |=> (s1_valid_reg && (s1_kind_reg == K_DONE) && !walk_ctl.busy))
        else $error("walk end did not produce a done result");

endmodule

`default_nettype wire

[hdl/cmt_offset_ram.sv]
`default_nettype none

module cmt_offset_ram
    import cmt_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             write_en,
    input  wire logic [$clog2(MAX_COLUMNS)-1:0]   write_addr,
    input  wire logic [OFFSET_W-1:0]              write_data,
    input  wire logic                             read_en,
    input  wire logic [$clog2(MAX_COLUMNS)-1:0]   read_addr,
    output logic      [OFFSET_W-1:0]              read_data
);

    logic [OFFSET_W-1:0] mem [MAX_COLUMNS];
    logic [OFFSET_W-1:0] read_q_reg;
    logic [OFFSET_W-1:0] bypass_data_reg;
    logic                bypass_reg;

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            mem[write_addr] <= write_data;
        end
        if (read_en)
        begin
            read_q_reg      <= mem[read_addr];
            bypass_data_reg <= write_data;
        end
    end

    // same-entry write in the read cycle wins over the stale array word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg <= 1'b0;
        end
        else if (read_en)
        begin
            bypass_reg <= write_en && (write_addr == read_addr);
        end
    end

    assign read_data = bypass_reg ? bypass_data_reg : read_q_reg;

endmodule

`default_nettype wire

[hdl/cmt_seed_unit.sv]
`default_nettype none

module cmt_seed_unit
    import cmt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire logic [8:0]          column,
    input  wire logic [7:0]          random_value,
    input  wire logic [3:0]          vertical_scale,
    output logic      [OFFSET_W-1:0] offset
);

    logic [4:0]                 previous_seed_reg;
    logic [4:0]                 previous_seed_next;
    logic signed [5:0]          chained;
    logic [4:0]                 seed;
    logic signed [OFFSET_W-1:0] product;

    always_comb
    begin
        chained = $signed({previous_seed_reg[4], previous_seed_reg})
                + $signed({4'b0000, mod3_byte(random_value)}) - 6'sd1;
        if (column == 9'd0)
        begin
            seed = 5'd0 - {1'b0, random_value[3:0]};
        end
        else if (chained > 6'sd0)
        begin
            seed = 5'd0;
        end
        else if (chained < SEED_FLOOR)
        begin
            seed = SEED_FLOOR[4:0];
        end
        else
        begin
            seed = chained[4:0];
        end
        product = $signed({{(OFFSET_W-5){seed[4]}}, seed})
                * $signed({{(OFFSET_W-4){1'b0}}, vertical_scale});
        offset  = product;
        previous_seed_next = load ? seed : previous_seed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            previous_seed_reg <= 5'd0;
        end
        else
        begin
            previous_seed_reg <= previous_seed_next;
        end
    end

endmodule

`default_nettype wire

[hdl/cmt_column_alu.sv]
`default_nettype none

module cmt_column_alu
    import cmt_pkg::*;
(
    input  wire logic [OFFSET_W-1:0] offset,
    input  wire logic [11:0]         row_count,
    input  wire logic [3:0]          vertical_scale,
    input  wire logic [10:0]         row,
    output logic      [OFFSET_W-1:0] melt_offset,
    output logic                     melt_moved,
    output out_item_t                query_result
);

    logic [11:0] level;
    logic [4:0]  base_step;
    logic [8:0]  step;
    logic [12:0] landing;
    logic [11:0] visible;

    always_comb
    begin
        level     = offset[11:0];
        base_step = (level < 12'(FAST_LIMIT)) ? (5'(level[3:0]) + 5'd1) : SLOW_STEP;
        step      = 9'(base_step) * 9'(vertical_scale);
        landing   = 13'(level) + 13'(step);

        melt_offset = offset;
        melt_moved  = 1'b0;
        if (offset[OFFSET_W-1])
        begin
            // waiting column counts up toward zero
            melt_offset = offset + OFFSET_W'(1);
            melt_moved  = 1'b1;
        end
        else if (level < row_count)
        begin
            melt_moved  = 1'b1;
            melt_offset = (landing >= 13'(row_count)) ? OFFSET_W'(row_count)
                                                       : OFFSET_W'(landing);
        end

        visible      = offset[OFFSET_W-1] ? 12'd0 : level;
        query_result = '0;
        if (12'(row) < visible)
        begin
            query_result.from_end_frame = 1'b1;
            query_result.source_row     = row;
        end
        else
        begin
            query_result.source_row = row - visible[10:0];
        end
    end

endmodule

`default_nettype wire

[hdl/cmt_walker.sv]
`default_nettype none

module cmt_walker
    import cmt_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic [$clog2(MAX_COLUMNS)-1:0]   last_column,
    input  wire logic [7:0]                       last_pass,
    output walk_ctl_t                             ctl,
    output logic      [$clog2(MAX_COLUMNS)-1:0]   addr
);

    localparam int ADDR_W = $clog2(MAX_COLUMNS);

    typedef enum logic [1:0] {W_IDLE, W_RUN, W_DRAIN} walk_state_t;

    walk_state_t       state_reg;
    logic [ADDR_W-1:0] column_reg;
    logic [ADDR_W-1:0] last_column_reg;
    logic [7:0]        pass_reg;
    logic [7:0]        last_pass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= W_IDLE;
            column_reg      <= '0;
            last_column_reg <= '0;
            pass_reg        <= 8'd0;
            last_pass_reg   <= 8'd0;
        end
        else
        begin
            case (state_reg)
                W_IDLE:
                begin
                    if (start)
                    begin
                        state_reg       <= W_RUN;
                        column_reg      <= '0;
                        pass_reg        <= 8'd0;
                        last_column_reg <= last_column;
                        last_pass_reg   <= last_pass;
                    end
                end
                W_RUN:
                begin
                    if (column_reg == last_column_reg)
                    begin
                        column_reg <= '0;
                        if (pass_reg == last_pass_reg)
                        begin
                            state_reg <= W_DRAIN;
                        end
                        else
                        begin
                            pass_reg <= pass_reg + 8'd1;
                        end
                    end
                    else
                    begin
                        column_reg <= column_reg + ADDR_W'(1);
                    end
                end
                W_DRAIN:
                begin
                    state_reg <= W_IDLE;
                end
                default:
                begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        ctl.issue = (state_reg == W_RUN);
        ctl.busy  = (state_reg != W_IDLE);
        ctl.drain = (state_reg == W_DRAIN);
        addr      = column_reg;
    end

endmodule

`default_nettype wire
